[src/alids_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package alids_pkg;

  localparam int unsigned LIST_DEPTH = 64;

  localparam logic [2:0] REQ_APPEND = 3'd0;
  localparam logic [2:0] REQ_INSERT = 3'd1;
  localparam logic [2:0] REQ_DELETE = 3'd2;
  localparam logic [2:0] REQ_SEARCH = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STS_FULL      = 2'd2;
  localparam logic [1:0] STS_RANGE     = 2'd3;

  typedef struct packed {
    logic cmp_en;
    logic is_read;
    logic wr_append;
    logic wr_insert;
    logic wr_delete;
  } alids_ctl_t;

endpackage
`default_nettype wire

[src/alids_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module alids_cell #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX   = 0,
  parameter int unsigned CW    = $clog2(DEPTH + 1),
  parameter int unsigned KW    = (CW > 7) ? CW : 7
) (
  input  wire                      clk,
  input  wire alids_pkg::alids_ctl_t ctl,
  input  wire logic signed [31:0]  item,
  input  wire logic [KW-1:0]       key,
  input  wire logic [CW-1:0]       count,
  input  wire logic signed [31:0]  left_val,
  input  wire logic signed [31:0]  right_val,
  input  wire logic                before_in,
  output logic                     before_out,
  output logic                     first,
  output logic signed [31:0]       ent
);
  import alids_pkg::*;

  logic hit;
  logic occupied;
  logic key_eq;
  logic key_gt;
  logic at_tail;

  assign occupied   = CW'(IDX) < count;
  assign at_tail    = CW'(IDX) == count;
  assign key_eq     = KW'(IDX) == key;
  assign key_gt     = KW'(IDX) > key;
  assign before_out = before_in | hit;
  assign first      = hit & ~before_in;

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      hit <= occupied && (ctl.is_read ? key_eq : (ent == item));
    end
    if (ctl.wr_append && at_tail) begin
      ent <= item;
    end else if (ctl.wr_insert && key_eq) begin
      ent <= item;
    end else if (ctl.wr_insert && key_gt) begin
      ent <= left_val;
    end else if (ctl.wr_delete && before_out) begin
      ent <= right_val;
    end
  end

endmodule
`default_nettype wire

[src/array_list_insert_delete_search.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel  Handshake             Payload
// in       in_valid / in_ready   req_type, item_value, position
// out      out_valid / out_ready status, found_index, read_value, entry_count
//
// Each transaction runs through accept, compare (every cell matches its entry, or
// its index on a read), and apply (the first-match flag ripples along the cell
// chain and the cells shift). Reset clears the count and the control; entries
// hold no reset. A stalled result holds the apply state; a new transaction is
// taken once the previous one has reached the output register.
module array_list_insert_delete_search #(
  parameter int unsigned DEPTH = alids_pkg::LIST_DEPTH
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire logic [2:0]          req_type,
  input  wire logic signed [31:0]  item_value,
  input  wire logic [6:0]          position,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic [1:0]               status,
  output logic [5:0]               found_index,
  output logic signed [31:0]       read_value,
  output logic [6:0]               entry_count
);
  import alids_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned KW = (CW > 7) ? CW : 7;
  localparam int unsigned IW = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  state_t              state;
  logic [2:0]          req_kind;
  logic signed [31:0]  req_value;
  logic [6:0]          req_pos;
  logic [CW-1:0]       count;

  alids_ctl_t          ctl;
  logic [KW-1:0]       key;
  logic                commit;

  logic signed [31:0]  ent_vec   [DEPTH];
  logic signed [31:0]  left_vec  [DEPTH];
  logic signed [31:0]  right_vec [DEPTH];
  logic [DEPTH:0]      before_vec;
  logic [DEPTH-1:0]    first_vec;
  logic                found;
  logic [IW-1:0]       hit_idx;
  logic signed [31:0]  hit_val;

  logic [1:0]          status_next;
  logic [31:0]         idx_next;
  logic signed [31:0]  value_next;
  logic [CW-1:0]       count_next;
  logic                do_app;
  logic                do_ins;
  logic                do_del;
  logic                full;

  assign in_ready      = (state == S_IDLE);
  assign commit        = (state == S_APPLY) && (!out_valid || out_ready);
  assign key           = (req_kind == REQ_INSERT) ? (KW'(req_pos) - KW'(1)) : KW'(req_pos);
  assign ctl.cmp_en    = (state == S_CMP);
  assign ctl.is_read   = (req_kind == REQ_READ);
  assign ctl.wr_append = commit && do_app;
  assign ctl.wr_insert = commit && do_ins;
  assign ctl.wr_delete = commit && do_del;
  assign before_vec[0] = 1'b0;
  assign found         = before_vec[DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign left_vec[g] = '0;
    end else begin : g_body
      assign left_vec[g] = ent_vec[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_vec[g] = ent_vec[g];
    end else begin : g_inner
      assign right_vec[g] = ent_vec[g+1];
    end

    alids_cell #(
      .DEPTH (DEPTH),
      .IDX   (g)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .item       (req_value),
      .key        (key),
      .count      (count),
      .left_val   (left_vec[g]),
      .right_val  (right_vec[g]),
      .before_in  (before_vec[g]),
      .before_out (before_vec[g+1]),
      .first      (first_vec[g]),
      .ent        (ent_vec[g])
    );
  end

  always_comb begin
    hit_idx = '0;
    hit_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_vec[i]) begin
        hit_idx = hit_idx | IW'(i);
        hit_val = hit_val | ent_vec[i];
      end
    end
  end

  always_comb begin
    full        = 32'(count) >= DEPTH;
    status_next = STS_OK;
    idx_next    = '0;
    value_next  = '0;
    count_next  = count;
    do_app      = 1'b0;
    do_ins      = 1'b0;
    do_del      = 1'b0;
    case (req_kind)
      REQ_APPEND: begin
        if (full) begin
          status_next = STS_FULL;
        end else begin
          idx_next   = 32'(count);
          value_next = req_value;
          count_next = count + CW'(1);
          do_app     = 1'b1;
        end
      end
      REQ_INSERT: begin
        if (full) begin
          status_next = STS_FULL;
        end else if (req_pos == 7'd0 || 32'(req_pos) > 32'(count) + 32'd1) begin
          status_next = STS_RANGE;
        end else begin
          idx_next   = 32'(req_pos) - 32'd1;
          value_next = req_value;
          count_next = count + CW'(1);
          do_ins     = 1'b1;
        end
      end
      REQ_DELETE: begin
        if (!found) begin
          status_next = STS_NOT_FOUND;
        end else begin
          idx_next   = 32'(hit_idx);
          value_next = req_value;
          count_next = count - CW'(1);
          do_del     = 1'b1;
        end
      end
      REQ_SEARCH: begin
        if (!found) begin
          status_next = STS_NOT_FOUND;
        end else begin
          idx_next   = 32'(hit_idx);
          value_next = req_value;
        end
      end
      REQ_READ: begin
        if (!found) begin
          status_next = STS_RANGE;
        end else begin
          idx_next   = 32'(hit_idx);
          value_next = hit_val;
        end
      end
      default: begin
        status_next = STS_RANGE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !commit) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_kind  <= req_type;
            req_value <= item_value;
            req_pos   <= position;
            state     <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (commit) begin
            count       <= count_next;
            status      <= status_next;
            found_index <= 6'(idx_next);
            read_value  <= value_next;
            entry_count <= 7'(count_next);
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= DEPTH)
    else $error("entry count above depth");

  a_single_first: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) |-> $onehot0(first_vec))
    else $error("more than one first-match cell");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (commit && do_app) |=> (count == $past(count) + CW'(1)))
    else $error("append did not advance the count");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STS_OK) |-> (found_index == 6'd0 && read_value == 32'sd0))
    else $error("failed transaction carries index or value");
`endif

endmodule
`default_nettype wire

[tb/sv/tb_array_list_insert_delete_search.sv]
`timescale 1ns / 1ps
module tb_array_list_insert_delete_search;
  import alids_pkg::*;

  localparam logic [2:0]          REQ_CODE_MAX = 3'd7;
  localparam logic signed [31:0]  VAL_MIN      = 32'sh8000_0000;
  localparam logic signed [31:0]  VAL_MAX      = 32'sh7FFF_FFFF;
  localparam int                  HOLD_CYCLES  = 150;
  localparam int                  QUIET_LIMIT  = 1000;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         index;
    logic signed [31:0] value;
    logic [6:0]         count;
  } list_result_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         req_type;
  logic signed [31:0] item_value;
  logic [6:0]         position;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         status;
  logic [5:0]         found_index;
  logic signed [31:0] read_value;
  logic [6:0]         entry_count;

  logic signed [31:0] shadow_list[$];
  list_result_t       pending_results[$];
  bit                 burst_mode;
  bit                 hold_request;
  int                 mismatches;
  int                 quiet_cycles;
  int                 longest_list;
  int                 req_seen[8];
  int                 status_seen[4];

  array_list_insert_delete_search u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .item_value  (item_value),
    .position    (position),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found_index (found_index),
    .read_value  (read_value),
    .entry_count (entry_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic list_result_t predict_list_op(input logic [2:0] kind,
                                                   input logic signed [31:0] val,
                                                   input logic [6:0] pos);
    list_result_t res;
    int           len;
    int           hit;
    res        = '0;
    res.status = STS_OK;
    len        = shadow_list.size();
    hit        = -1;
    case (kind)
      REQ_APPEND: begin
        if (len >= LIST_DEPTH) begin
          res.status = STS_FULL;
        end else begin
          res.index = 6'(len);
          res.value = val;
          shadow_list.push_back(val);
        end
      end
      REQ_INSERT: begin
        if (len >= LIST_DEPTH) begin
          res.status = STS_FULL;
        end else if (pos == 7'd0 || int'(pos) > len + 1) begin
          res.status = STS_RANGE;
        end else begin
          res.index = 6'(pos - 7'd1);
          res.value = val;
          shadow_list.insert(int'(pos) - 1, val);
        end
      end
      REQ_DELETE, REQ_SEARCH: begin
        for (int i = 0; i < len; i++) begin
          if (hit < 0 && shadow_list[i] == val) hit = i;
        end
        if (hit < 0) begin
          res.status = STS_NOT_FOUND;
        end else begin
          res.index = 6'(hit);
          res.value = shadow_list[hit];
          if (kind == REQ_DELETE) shadow_list.delete(hit);
        end
      end
      REQ_READ: begin
        if (int'(pos) >= len) begin
          res.status = STS_RANGE;
        end else begin
          res.index = 6'(pos);
          res.value = shadow_list[pos];
        end
      end
      default: res.status = STS_RANGE;
    endcase
    res.count = 7'(shadow_list.size());
    if (shadow_list.size() > longest_list) longest_list = shadow_list.size();
    return res;
  endfunction

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(0, 15) - 8;
      2: begin
        case ($urandom_range(0, 2))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          default: v = 0;
        endcase
      end
      default: begin
        if (shadow_list.size() > 0) v = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
        else v = $urandom;
      end
    endcase
    return v;
  endfunction

  task automatic send_req(input logic [2:0] kind, input logic signed [31:0] val,
                          input logic [6:0] pos);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    item_value <= val;
    position   <= pos;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_list_op(kind, val, pos));
    req_seen[kind]++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_list();
    send_req(REQ_SEARCH, 0, 7'd0);
    send_req(REQ_DELETE, -1, 7'd0);
    send_req(REQ_READ, 0, 7'd0);
    send_req(REQ_READ, VAL_MAX, 7'd127);
    send_req(REQ_INSERT, 7, 7'd0);
    send_req(REQ_INSERT, 7, 7'd2);
    for (int k = int'(REQ_READ) + 1; k <= int'(REQ_CODE_MAX); k++) begin
      send_req(3'(k), $urandom, 7'($urandom_range(0, 127)));
    end
    drain_results();
  endtask

  task automatic test_basic_edits();
    send_req(REQ_INSERT, VAL_MIN, 7'd1);
    send_req(REQ_APPEND, VAL_MAX, 7'd127);
    send_req(REQ_APPEND, 0, 7'd0);
    send_req(REQ_APPEND, -1, 7'd64);
    send_req(REQ_INSERT, 5, 7'd3);
    send_req(REQ_INSERT, VAL_MAX, 7'd6);
    send_req(REQ_INSERT, 9, 7'd8);
    send_req(REQ_SEARCH, VAL_MAX, 7'd0);
    send_req(REQ_DELETE, VAL_MAX, 7'd0);
    send_req(REQ_SEARCH, VAL_MAX, 7'd0);
    send_req(REQ_READ, 0, 7'd0);
    send_req(REQ_READ, 0, 7'd4);
    send_req(REQ_READ, 0, 7'd5);
    send_req(REQ_DELETE, 32'sd12345, 7'd0);
    drain_results();
  endtask

  task automatic test_full_list();
    int fill;
    fill = LIST_DEPTH - shadow_list.size();
    for (int i = 0; i < fill; i++) send_req(REQ_APPEND, pick_value(), 7'($urandom_range(0, 127)));
    send_req(REQ_APPEND, pick_value(), 7'd0);
    send_req(REQ_INSERT, pick_value(), 7'd1);
    send_req(REQ_INSERT, pick_value(), 7'd0);
    send_req(REQ_READ, 0, 7'd63);
    send_req(REQ_READ, 0, 7'd64);
    send_req(REQ_SEARCH, shadow_list[LIST_DEPTH - 1], 7'd0);
    send_req(REQ_DELETE, shadow_list[LIST_DEPTH - 1], 7'd0);
    send_req(REQ_INSERT, VAL_MIN, 7'(shadow_list.size() + 1));
    send_req(REQ_READ, 0, 7'd63);
    drain_results();
  endtask

  task automatic test_output_backpressure();
    logic [2:0] kind;
    drain_results();
    burst_mode   = 1'b1;
    hold_request = 1'b1;
    for (int n = 0; n < 24; n++) begin
      kind = (shadow_list.size() < LIST_DEPTH) ? REQ_APPEND : REQ_SEARCH;
      if (n % 3 == 2) kind = REQ_READ;
      send_req(kind, pick_value(), 7'($urandom_range(0, 127)));
    end
    drain_results();
    burst_mode = 1'b0;
  endtask

  task automatic test_random_traffic(input int rounds, input int per_round);
    int                 add_share;
    int                 rest;
    int                 roll;
    int                 len;
    logic [2:0]         kind;
    logic signed [31:0] val;
    logic [6:0]         pos;
    for (int r = 0; r < rounds; r++) begin
      case (r % 4)
        0, 1:    add_share = 62;
        2:       add_share = 16;
        default: add_share = 36;
      endcase
      rest       = 100 - add_share;
      burst_mode = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < per_round; n++) begin
        len  = shadow_list.size();
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 3) kind = 3'($urandom_range(int'(REQ_READ) + 1, REQ_CODE_MAX));
        else if (roll < add_share / 2) kind = REQ_APPEND;
        else if (roll < add_share) kind = REQ_INSERT;
        else if (roll < add_share + rest / 2) kind = REQ_DELETE;
        else if (roll < add_share + (3 * rest) / 4) kind = REQ_SEARCH;
        else kind = REQ_READ;
        val = pick_value();
        pos = 7'($urandom_range(0, 127));
        if ((kind == REQ_DELETE || kind == REQ_SEARCH) && len > 0 && $urandom_range(0, 9) < 7)
          val = shadow_list[$urandom_range(0, len - 1)];
        if (kind == REQ_INSERT && $urandom_range(0, 9) != 0) pos = 7'($urandom_range(1, len + 1));
        if (kind == REQ_READ && len > 0 && $urandom_range(0, 9) != 0)
          pos = 7'($urandom_range(0, len - 1));
        send_req(kind, val, pos);
      end
    end
    burst_mode = 1'b0;
    drain_results();
  endtask

  initial begin : result_checker
    list_result_t exp;
    int           stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        stall        = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        stall = burst_mode ? 0 : $urandom_range(0, 4);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d index %0d value %0d count %0d",
               status, found_index, read_value, entry_count);
        mismatches++;
      end else begin
        exp = pending_results.pop_front();
        status_seen[exp.status]++;
        if (status !== exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, status);
          mismatches++;
        end
        if (found_index !== exp.index) begin
          $error("found_index: expected %0d, got %0d", exp.index, found_index);
          mismatches++;
        end
        if (read_value !== exp.value) begin
          $error("read_value: expected %0d, got %0d", exp.value, read_value);
          mismatches++;
        end
        if (entry_count !== exp.count) begin
          $error("entry_count: expected %0d, got %0d", exp.count, entry_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("array_list_insert_delete_search verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    req_type     = REQ_APPEND;
    item_value   = 0;
    position     = 7'd0;
    burst_mode   = 1'b0;
    hold_request = 1'b0;
    mismatches   = 0;
    quiet_cycles = 0;
    longest_list = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_list();
    test_basic_edits();
    test_full_list();
    test_output_backpressure();
    test_random_traffic(14, 90);

    repeat (20) @(posedge clk);
    $display("Ran %0d appends, %0d inserts, %0d deletes, %0d searches, %0d reads, %0d bad codes;",
             req_seen[REQ_APPEND], req_seen[REQ_INSERT], req_seen[REQ_DELETE],
             req_seen[REQ_SEARCH], req_seen[REQ_READ], req_seen[5] + req_seen[6] + req_seen[7]);
    $display("longest list %0d, results ok %0d, not found %0d, full %0d, out of range %0d.",
             longest_list, status_seen[STS_OK], status_seen[STS_NOT_FOUND],
             status_seen[STS_FULL], status_seen[STS_RANGE]);
    if (mismatches == 0) begin
      $display("array_list_insert_delete_search verification clean");
    end else begin
      $display("array_list_insert_delete_search verification failed");
    end
    $finish;
  end

endmodule
